// ===== rtl/rsl_pkg.sv =====
// Shared types, constants and helper functions for the ray versus sphere list
// nearest-hit block. Every module of the block imports this package.
`default_nettype none

package rsl_pkg;

  localparam int MAX_SPHERES_DEF = 64;

  // Q16.16 constants.
  localparam logic signed [31:0] Q_ONE    = 32'sd65536;
  localparam logic signed [31:0] T_MIN    = 32'sd655;
  localparam logic signed [31:0] FAR_DIST = 32'sh7fffffff;
  localparam logic signed [31:0] OFS_Y    = 32'sd196608;   // 3.0
  localparam logic signed [31:0] OFS_Z    = -32'sd262144;  // -4.0

  // Widths of the shared arithmetic units.
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 32;
  localparam int SQRT_IN_W = 64;
  localparam int SQRT_RT_W = 32;
  localparam int ACC_W     = 50;

  localparam logic OPER_LOAD  = 1'b0;
  localparam logic OPER_TRACE = 1'b1;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_FLOOR  = 2'd1;
  localparam logic [1:0] KIND_SPHERE = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [5:0]        sphere_index;
    logic signed [31:0] sphere_k;
    logic signed [31:0] sphere_j;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } in_t;

  typedef struct packed {
    logic [1:0]         hit_kind;
    logic signed [31:0] distance;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
  } out_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_TRACE, OP_PDIV, OP_PFIN, OP_READ, OP_PSET, OP_MUL,
    OP_ACC, OP_SQ1, OP_SFIN, OP_TAKE, OP_SQ2, OP_LEN, OP_NDIV, OP_NFIN
  } op_t;

  // Product terms of the per-sphere sequence, in issue order.
  typedef enum logic [3:0] {
    TM_PD0, TM_PD1, TM_PD2, TM_PP0, TM_PP1, TM_PP2, TM_BB,
    TM_DS0, TM_DS1, TM_DS2, TM_VV0, TM_VV1, TM_VV2
  } term_t;

  typedef struct packed {
    op_t        op;
    term_t      term;
    logic [1:0] comp;
    logic       next_idx;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic unit_done;
    logic none_tested;
    logic last;
    logic quad_ok;
    logic s_ok;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh000000007fffffff) begin
      r = FAR_DIST;
    end else if (x < -64'sh0000000080000000) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Magnitude of a signed word as an unsigned word; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    logic [31:0] r;
    if (x[31]) begin
      r = ~x + 32'd1;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rsl_div.sv =====
// Iterative restoring divider on magnitudes, one quotient bit per cycle.
// Depends on rsl_pkg for its widths.
`default_nettype none

module rsl_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [rsl_pkg::DIV_NUM_W-1:0]   num,
  input  wire logic [rsl_pkg::DIV_DEN_W-1:0]   den,
  output logic                                 busy,
  output logic                                 done,
  output logic [rsl_pkg::DIV_NUM_W-1:0]        quo
);
  import rsl_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W:0]   shifted;
  logic                 fits;

  assign shifted = {rem, quo[DIV_NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(DIV_NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_r <= den;
      quo   <= num;
      cnt   <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_DEN_W'(shifted - {1'b0, den_r});
      end else begin
        rem <= shifted[DIV_DEN_W-1:0];
      end
      quo <= {quo[DIV_NUM_W-2:0], fits};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rsl_sqrt.sv =====
// Iterative floored integer square root, one result bit per cycle.
// Depends on rsl_pkg for its widths.
`default_nettype none

module rsl_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rsl_pkg::SQRT_IN_W-1:0] val,
  output logic                               busy,
  output logic                               done,
  output logic [rsl_pkg::SQRT_RT_W-1:0]      root
);
  import rsl_pkg::*;

  logic [SQRT_IN_W-1:0] rest;
  logic [SQRT_IN_W-1:0] r;
  logic [SQRT_IN_W-1:0] bitm;
  logic [SQRT_IN_W-1:0] trial;

  assign trial = r + bitm;
  assign root  = r[SQRT_RT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitm[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Leading steps with the test bit above the operand leave the root at zero.
  always_ff @(posedge clk) begin
    if (start) begin
      rest <= val;
      r    <= '0;
      bitm <= SQRT_IN_W'(1) << (SQRT_IN_W - 2);
    end else if (busy) begin
      if (rest >= trial) begin
        rest <= rest - trial;
        r    <= (r >> 1) + bitm;
      end else begin
        r <= r >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rsl_dp.sv =====
// Datapath: sphere table, ray registers, one multiplier, accumulator and
// the shared divider and square root units. Depends on rsl_pkg, rsl_div, rsl_sqrt.
`default_nettype none

module rsl_dp #(
  parameter int MAX_SPHERES = rsl_pkg::MAX_SPHERES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rsl_pkg::cmd_t cmd,
  output rsl_pkg::sts_t      sts,
  input  wire rsl_pkg::in_t  in_data,
  input  wire logic          cfg_we,
  input  wire logic [6:0]    cfg_data,
  output rsl_pkg::out_t      out_data
);
  import rsl_pkg::*;

  localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CW = $clog2(MAX_SPHERES + 1);

  logic [63:0] mem [MAX_SPHERES];
  logic [63:0] rd_q;

  logic [6:0]    count;
  logic [CW-1:0] eff;
  logic [CW-1:0] idx;
  logic [AW+5:0] widx_ext;

  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic signed [31:0] p   [3];
  logic signed [31:0] v   [3];
  logic signed [31:0] nrm [3];
  logic signed [31:0] b, c, b2, s, best;
  logic [1:0]         kind;
  logic [31:0]        len;

  logic signed [31:0]      ma, mb;
  logic signed [63:0]      prod;
  logic signed [47:0]      fl;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_sum;

  logic                    div_start, div_busy, div_done, div_neg;
  logic [DIV_NUM_W-1:0]    div_num, quo;
  logic [DIV_DEN_W-1:0]    div_den;
  logic signed [48:0]      q_signed;
  logic signed [31:0]      q_sat;

  logic                    sq_start, sq_busy, sq_done;
  logic [SQRT_IN_W-1:0]    sq_val;
  logic [SQRT_RT_W-1:0]    sq_root;
  logic [32:0]             qd;
  logic signed [33:0]      s_full;

  rsl_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quo(quo)
  );

  rsl_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .val(sq_val),
    .busy(sq_busy), .done(sq_done), .root(sq_root)
  );

  assign eff = (32'(count) > MAX_SPHERES) ? CW'(MAX_SPHERES) : CW'(count);
  assign widx_ext = (AW + 6)'(in_data.sphere_index);

  // Multiplier operand selection per product term.
  always_comb begin
    ma = p[0];
    mb = dir[0];
    case (cmd.term)
      TM_PD0: begin ma = p[0]; mb = dir[0]; end
      TM_PD1: begin ma = p[1]; mb = dir[1]; end
      TM_PD2: begin ma = p[2]; mb = dir[2]; end
      TM_PP0: begin ma = p[0]; mb = p[0]; end
      TM_PP1: begin ma = p[1]; mb = p[1]; end
      TM_PP2: begin ma = p[2]; mb = p[2]; end
      TM_BB:  begin ma = b;    mb = b;    end
      TM_DS0: begin ma = dir[0]; mb = s; end
      TM_DS1: begin ma = dir[1]; mb = s; end
      TM_DS2: begin ma = dir[2]; mb = s; end
      TM_VV0: begin ma = v[0]; mb = v[0]; end
      TM_VV1: begin ma = v[1]; mb = v[1]; end
      TM_VV2: begin ma = v[2]; mb = v[2]; end
      default: begin ma = p[0]; mb = dir[0]; end
    endcase
  end

  // The product bits above the fraction are the floored Q16.16 product.
  assign fl      = prod[63:16];
  assign acc_sum = acc + ACC_W'(fl);

  assign q_signed = div_neg ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
  assign q_sat    = sat32(64'(q_signed));

  assign qd     = 33'({b2[31], b2} - {c[31], c});
  assign s_full = -34'(b) - signed'({2'b00, sq_root});

  always_comb begin
    div_start = 1'b0;
    div_num   = {mag32(-org[2]), 16'd0};
    div_den   = mag32(dir[2]);
    if (cmd.op == OP_PDIV) begin
      div_start = 1'b1;
    end else if (cmd.op == OP_NDIV) begin
      div_start = 1'b1;
      div_num   = {mag32(v[cmd.comp]), 16'd0};
      div_den   = len;
    end
  end

  always_comb begin
    sq_start = (cmd.op == OP_SQ1) || (cmd.op == OP_SQ2);
    if (cmd.op == OP_SQ2) begin
      sq_val = {acc[47:0], 16'd0};
    end else begin
      sq_val = {15'd0, qd, 16'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && 32'(in_data.sphere_index) < MAX_SPHERES) begin
      mem[widx_ext[AW-1:0]] <= {in_data.sphere_k, in_data.sphere_j};
    end
    if (cmd.op == OP_READ) begin
      rd_q <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cfg_we) begin
      count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_NONE;
      best <= FAR_DIST;
    end else begin
      case (cmd.op)
        OP_TRACE: begin
          kind <= KIND_NONE;
          best <= FAR_DIST;
        end
        OP_PFIN: begin
          if (dir[2] != 32'sd0 && q_sat > T_MIN) begin
            kind <= KIND_FLOOR;
            best <= q_sat;
          end
        end
        OP_TAKE: begin
          kind <= KIND_SPHERE;
          best <= s;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_TRACE: begin
        org[0] <= in_data.origin_x;
        org[1] <= in_data.origin_y;
        org[2] <= in_data.origin_z;
        dir[0] <= in_data.dir_x;
        dir[1] <= in_data.dir_y;
        dir[2] <= in_data.dir_z;
        nrm[0] <= '0;
        nrm[1] <= '0;
        nrm[2] <= '0;
        idx    <= '0;
      end
      OP_PDIV: begin
        div_neg <= (org[2] > 32'sd0) ^ dir[2][31];
      end
      OP_PFIN: begin
        if (dir[2] != 32'sd0 && q_sat > T_MIN) begin
          nrm[0] <= '0;
          nrm[1] <= '0;
          nrm[2] <= Q_ONE;
        end
      end
      OP_PSET: begin
        p[0] <= sat32(64'(org[0]) + 64'(signed'(rd_q[63:32])));
        p[1] <= sat32(64'(org[1]) + 64'(OFS_Y));
        p[2] <= sat32(64'(org[2]) + 64'(OFS_Z) + 64'(signed'(rd_q[31:0])));
      end
      OP_MUL: begin
        prod <= 64'(ma) * 64'(mb);
      end
      OP_ACC: begin
        case (cmd.term)
          TM_PD0, TM_PP0, TM_VV0: acc <= ACC_W'(fl);
          TM_PD1, TM_PP1, TM_VV1, TM_VV2: acc <= acc_sum;
          TM_PD2: b <= sat32(64'(acc_sum));
          TM_PP2: c <= sat32(64'(acc_sum) - 64'(Q_ONE));
          TM_BB:  b2 <= sat32(64'(fl));
          TM_DS0: v[0] <= sat32(64'(p[0]) + 64'(fl));
          TM_DS1: v[1] <= sat32(64'(p[1]) + 64'(fl));
          TM_DS2: v[2] <= sat32(64'(p[2]) + 64'(fl));
          default: begin
          end
        endcase
      end
      OP_SFIN: begin
        s <= sat32(64'(s_full));
      end
      OP_LEN: begin
        len <= sq_root;
      end
      OP_NDIV: begin
        div_neg <= v[cmd.comp][31];
      end
      OP_NFIN: begin
        nrm[cmd.comp] <= (len != 32'd0) ? q_sat : 32'sd0;
      end
      default: begin
      end
    endcase
    if (cmd.next_idx) begin
      idx <= idx + 1'b1;
    end
    if (cmd.out_load) begin
      out_data.hit_kind <= kind;
      out_data.distance <= best;
      out_data.normal_x <= nrm[0];
      out_data.normal_y <= nrm[1];
      out_data.normal_z <= nrm[2];
    end
  end

  always_comb begin
    sts.unit_done   = div_done | sq_done;
    sts.none_tested = (eff == '0);
    sts.last        = ((CW + 1)'(idx) + 1'b1) >= (CW + 1)'(eff);
    sts.quad_ok     = b2 > c;
    sts.s_ok        = (s < best) && (s > T_MIN);
  end

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(div_busy && sq_busy))
    else $error("divider and square root unit busy together");

  a_none_far: assert property (@(posedge clk) disable iff (rst)
    kind == KIND_NONE |-> best == FAR_DIST)
    else $error("no hit recorded but distance is not the far value");

  a_sphere_dist: assert property (@(posedge clk) disable iff (rst)
    kind == KIND_SPHERE |-> best > T_MIN)
    else $error("sphere hit kept at or below the minimum distance");

  a_plane_start: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_PFIN |-> $past(cmd.op) == OP_PDIV || div_done)
    else $error("plane result taken before the division finished");

endmodule

`default_nettype wire

// ===== rtl/rsl_ctrl.sv =====
// Controller: sequences the plane test and the walk over the sphere table,
// and owns both handshakes. Depends on rsl_pkg.
`default_nettype none

module rsl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_oper,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rsl_pkg::cmd_t      cmd,
  input  wire rsl_pkg::sts_t sts
);
  import rsl_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_PSTART = 17'h00002,
    S_PWAIT  = 17'h00004,
    S_READ   = 17'h00008,
    S_PSET   = 17'h00010,
    S_MUL    = 17'h00020,
    S_ACC    = 17'h00040,
    S_CMP    = 17'h00080,
    S_SQS    = 17'h00100,
    S_SQW    = 17'h00200,
    S_TEST   = 17'h00400,
    S_LSTART = 17'h00800,
    S_LWAIT  = 17'h01000,
    S_NSTART = 17'h02000,
    S_NWAIT  = 17'h04000,
    S_NEXT   = 17'h08000,
    S_OUT    = 17'h10000
  } state_t;

  state_t     state, state_next;
  term_t      term, term_next;
  logic [1:0] comp, comp_next;
  logic       out_valid_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    term_next    = term;
    comp_next    = comp;
    in_ready     = 1'b0;
    cmd.op       = OP_NOP;
    cmd.term     = term;
    cmd.comp     = comp;
    cmd.next_idx = 1'b0;
    cmd.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_oper == OPER_LOAD) begin
            cmd.op = OP_LOAD;
          end else begin
            cmd.op     = OP_TRACE;
            state_next = S_PSTART;
          end
        end
      end
      S_PSTART: begin
        cmd.op     = OP_PDIV;
        state_next = S_PWAIT;
      end
      S_PWAIT: begin
        if (sts.unit_done) begin
          cmd.op     = OP_PFIN;
          state_next = sts.none_tested ? S_OUT : S_READ;
        end
      end
      S_READ: begin
        cmd.op     = OP_READ;
        state_next = S_PSET;
      end
      S_PSET: begin
        cmd.op     = OP_PSET;
        term_next  = TM_PD0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op     = OP_ACC;
        state_next = S_MUL;
        case (term)
          TM_PD0: term_next = TM_PD1;
          TM_PD1: term_next = TM_PD2;
          TM_PD2: term_next = TM_PP0;
          TM_PP0: term_next = TM_PP1;
          TM_PP1: term_next = TM_PP2;
          TM_PP2: term_next = TM_BB;
          TM_BB:  state_next = S_CMP;
          TM_DS0: term_next = TM_DS1;
          TM_DS1: term_next = TM_DS2;
          TM_DS2: term_next = TM_VV0;
          TM_VV0: term_next = TM_VV1;
          TM_VV1: term_next = TM_VV2;
          TM_VV2: state_next = S_LSTART;
          default: state_next = S_NEXT;
        endcase
      end
      S_CMP: begin
        state_next = sts.quad_ok ? S_SQS : S_NEXT;
      end
      S_SQS: begin
        cmd.op     = OP_SQ1;
        state_next = S_SQW;
      end
      S_SQW: begin
        if (sts.unit_done) begin
          cmd.op     = OP_SFIN;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (sts.s_ok) begin
          cmd.op     = OP_TAKE;
          term_next  = TM_DS0;
          state_next = S_MUL;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_LSTART: begin
        cmd.op     = OP_SQ2;
        state_next = S_LWAIT;
      end
      S_LWAIT: begin
        if (sts.unit_done) begin
          cmd.op     = OP_LEN;
          comp_next  = 2'd0;
          state_next = S_NSTART;
        end
      end
      S_NSTART: begin
        cmd.op     = OP_NDIV;
        state_next = S_NWAIT;
      end
      S_NWAIT: begin
        if (sts.unit_done) begin
          cmd.op = OP_NFIN;
          if (comp == 2'd2) begin
            state_next = S_NEXT;
          end else begin
            comp_next  = comp + 2'd1;
            state_next = S_NSTART;
          end
        end
      end
      S_NEXT: begin
        cmd.next_idx = 1'b1;
        state_next   = sts.last ? S_OUT : S_READ;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A waiting word stays until taken; a new one loads only into a free slot.
  assign out_valid_next = (state == S_OUT && slot_free) ? 1'b1 : (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      term      <= TM_PD0;
      comp      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      term      <= term_next;
      comp      <= comp_next;
      out_valid <= out_valid_next;
    end
  end

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result word raised outside the output step");

  a_wait_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_SQW && !sts.unit_done |=> state == S_SQW)
    else $error("square root wait left without completion");

  a_trace_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_oper == OPER_TRACE |=> state == S_PSTART)
    else $error("trace word did not start the plane test");

endmodule

`default_nettype wire

// ===== rtl/ray_sphere_list_nearest_hit.sv =====
// Top level of the nearest-hit unit: ray against the floor plane and a table
// of unit spheres. Depends on rsl_pkg, rsl_ctrl and rsl_dp.
//
//   channel   direction  handshake              word
//   in        input      in_valid / in_ready    rsl_pkg::in_t  (load or trace)
//   out       output     out_valid / out_ready  rsl_pkg::out_t (one per trace)
//   cfg       input      cfg_we                 sphere_count, 7 bits
//
// A load writes one sphere table entry. A trace runs the plane division, then
// per sphere the product terms, a square root when the ray line meets the
// sphere, and one more square root and three divisions when that sphere becomes
// the nearest hit, on the shared 48-step divider and 32-step square root unit.
// Reset clears the controller, the sphere count and the output valid flag;
// the sphere table holds nothing defined until loaded.
// A trace waits in its last step while an earlier result word is not yet taken.
`default_nettype none

module ray_sphere_list_nearest_hit #(
  parameter int MAX_SPHERES = rsl_pkg::MAX_SPHERES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rsl_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rsl_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [6:0]    cfg_data
);
  import rsl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rsl_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_oper(in_data.operation),
    .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .sts(sts)
  );

  rsl_dp #(
    .MAX_SPHERES(MAX_SPHERES)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .out_data(out_data)
  );

endmodule

`default_nettype wire
